FILE: src/ccpf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the credit checked packet FIFO.
// No dependencies; used by ccpf_credit, ccpf_queue and the top level.
package ccpf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned HANDLE_PW = 16;
  localparam int unsigned LEN_W     = 22;
  localparam int unsigned BITS_W    = 13;
  localparam int unsigned OCC_W     = 26;
  localparam int unsigned COUNT_PW  = 5;

  // Defaults for the top-level parameters
  localparam int unsigned QUEUE_DEPTH_DEF  = 16;
  localparam int unsigned HANDLE_WIDTH_DEF = 16;

  // Milli-bit scale
  localparam logic [9:0] SCALE = 10'd1000;

  // floor(x / 1000) for x < 2^22: x * ceil(2^32 / 1000) >> 32
  localparam logic [22:0] DIV1000_RECIP = 23'd4294968;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_PUSH    = 2'd1,
    OP_POP     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_OVER_CAPACITY = 2'd1,
    ERR_STORE_FULL    = 2'd2
  } err_t;

  typedef struct packed {
    op_t                    operation;
    logic [HANDLE_PW-1:0]   packet_handle;
    logic [LEN_W-1:0]       length_scaled;
  } in_item_t;

  typedef struct packed {
    logic                   granted;
    err_t                   error_code;
    logic                   head_valid;
    logic [HANDLE_PW-1:0]   head_handle;
    logic [BITS_W-1:0]      head_length_bits;
    logic [OCC_W-1:0]       occupancy_scaled;
    logic [COUNT_PW-1:0]    entry_count;
  } out_item_t;

  // Requests into the queue
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // Queue status: flags for this transfer and the head view after it
  typedef struct packed {
    logic                   full;
    logic                   pop_taken;
    logic [LEN_W-1:0]       freed_len;
    logic                   head_valid;
    logic [HANDLE_PW-1:0]   head_handle;
    logic [BITS_W-1:0]      head_bits;
    logic [COUNT_PW-1:0]    entry_count;
  } q_stat_t;

  // Requests into the credit counter
  typedef struct packed {
    logic                   reserve;
    logic                   release_len;
  } cr_ctrl_t;

  typedef struct packed {
    logic                   granted;
    logic                   over_cap;
    logic [OCC_W-1:0]       occupancy;
  } cr_stat_t;

  function automatic logic [BITS_W-1:0] div1000(input logic [LEN_W-1:0] len);
    logic [LEN_W+23-1:0] prod;
    prod = (LEN_W + 23)'(len) * (LEN_W + 23)'(DIV1000_RECIP);
    return prod[LEN_W+23-1:32];
  endfunction

endpackage

FILE: src/ccpf_credit.sv
`timescale 1ns / 1ps
// Occupancy credit counter with the scaled capacity register.
// Depends on ccpf_pkg.
module ccpf_credit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ccpf_pkg::CAP_W-1:0]    cfg_wr_data,
  input  ccpf_pkg::cr_ctrl_t            ctrl,
  input  logic [ccpf_pkg::LEN_W-1:0]    req_len,
  input  logic [ccpf_pkg::LEN_W-1:0]    freed_len,
  output ccpf_pkg::cr_stat_t            stat
);

  localparam int unsigned OW = ccpf_pkg::OCC_W;

  logic [OW-1:0] cap_r, cap_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW:0]   sum;
  logic [OW-1:0] freed;
  logic          over_cap;
  logic          fits;

  assign cap_nxt  = cfg_wr_en ? OW'(cfg_wr_data) * OW'(ccpf_pkg::SCALE) : cap_r;
  assign sum      = (OW + 1)'(occ_r) + (OW + 1)'(req_len);
  assign freed    = OW'(freed_len);
  assign over_cap = OW'(req_len) > cap_r;
  assign fits     = sum <= (OW + 1)'(cap_r);

  always_comb begin
    occ_nxt = occ_r;
    if (ctrl.reserve && !over_cap && fits) begin
      occ_nxt = sum[OW-1:0];
    end else if (ctrl.release_len) begin
      // saturate at zero
      occ_nxt = (freed >= occ_r) ? '0 : occ_r - freed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      occ_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      occ_r <= occ_nxt;
    end
  end

  assign stat.granted   = ctrl.reserve && !over_cap && fits;
  assign stat.over_cap  = ctrl.reserve && over_cap;
  assign stat.occupancy = occ_nxt;

endmodule

FILE: src/ccpf_queue.sv
`timescale 1ns / 1ps
// Packet handle FIFO: entry registers, pointers, count and head register.
// Depends on ccpf_pkg.
module ccpf_queue #(
  parameter int unsigned QUEUE_DEPTH  = ccpf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_WIDTH = ccpf_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ccpf_pkg::q_ctrl_t                 ctrl,
  input  logic [ccpf_pkg::HANDLE_PW-1:0]    push_handle,
  input  logic [ccpf_pkg::LEN_W-1:0]        push_len,
  output ccpf_pkg::q_stat_t                 stat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0]          handle;
    logic [ccpf_pkg::LEN_W-1:0]       len;
    logic [ccpf_pkg::BITS_W-1:0]      bits;
  } entry_t;

  entry_t             store_r [QUEUE_DEPTH];
  entry_t             head_r, head_nxt;
  entry_t             in_entry;
  logic [PTR_W-1:0]   head_ptr_r, head_ptr_nxt, head_ptr_inc;
  logic [PTR_W-1:0]   tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               full, empty, push_ok, pop_ok;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign push_ok = ctrl.push && !full;
  assign pop_ok  = ctrl.pop && !empty;

  assign in_entry.handle = HANDLE_WIDTH'(push_handle);
  assign in_entry.len    = push_len;
  assign in_entry.bits   = ccpf_pkg::div1000(push_len);

  assign head_ptr_inc = (head_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_r + 1'b1;
  assign head_ptr_nxt = pop_ok ? head_ptr_inc : head_ptr_r;
  assign tail_ptr_nxt = !push_ok ? tail_ptr_r :
                        (tail_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Head after this transfer: next slot on pop, incoming entry on push into empty
  always_comb begin
    head_nxt = head_r;
    if (pop_ok) begin
      head_nxt = store_r[head_ptr_inc];
    end else if (push_ok && empty) begin
      head_nxt = in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store_r[tail_ptr_r] <= in_entry;
    end
    head_r <= head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r <= '0;
      tail_ptr_r <= '0;
      count_r    <= '0;
    end else begin
      head_ptr_r <= head_ptr_nxt;
      tail_ptr_r <= tail_ptr_nxt;
      count_r    <= count_nxt;
    end
  end

  assign stat.full        = full;
  assign stat.pop_taken   = pop_ok;
  assign stat.freed_len   = head_r.len;
  assign stat.head_valid  = count_nxt != '0;
  assign stat.head_handle = (count_nxt != '0) ? ccpf_pkg::HANDLE_PW'(head_nxt.handle) : '0;
  assign stat.head_bits   = (count_nxt != '0) ? head_nxt.bits : '0;
  assign stat.entry_count = ccpf_pkg::COUNT_PW'(count_nxt);

endmodule

FILE: src/credit_checked_packet_fifo.sv
`timescale 1ns / 1ps
// Top level of the credit checked packet FIFO: handshake and result register.
// Depends on ccpf_pkg, ccpf_credit and ccpf_queue.
//
//   channel   ports                          direction  payload
//   input     in_valid/in_ready/in_data       in         ccpf_pkg::in_item_t
//   result    out_valid/out_ready/out_data    out        ccpf_pkg::out_item_t
//   config    cfg_wr_en/cfg_wr_data           in         capacity in bits
//
// An accepted item updates credit and queue state and loads its result at
// the accepting edge; one transfer per cycle while out_ready stays high.
// in_ready is high while the result register is empty or drains this cycle,
// so a stalled out_ready holds back at most one result.
// Synchronous active-low reset clears pointers, count, occupancy, capacity
// and the result valid flag; entry contents are not reset.
module credit_checked_packet_fifo #(
  parameter int unsigned QUEUE_DEPTH  = ccpf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_WIDTH = ccpf_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ccpf_pkg::in_item_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output ccpf_pkg::out_item_t           out_data,
  // capacity register
  input  logic                          cfg_wr_en,
  input  logic [ccpf_pkg::CAP_W-1:0]    cfg_wr_data
);

  logic                 accept;
  ccpf_pkg::q_ctrl_t    q_ctrl;
  ccpf_pkg::q_stat_t    q_stat;
  ccpf_pkg::cr_ctrl_t   cr_ctrl;
  ccpf_pkg::cr_stat_t   cr_stat;
  ccpf_pkg::out_item_t  res_nxt, res_r;
  ccpf_pkg::err_t       err;
  logic                 out_valid_r, out_valid_nxt;

  // Result register empties on a transfer out, so a new item may enter together
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode operation; code 3 does nothing
  always_comb begin
    q_ctrl  = '0;
    cr_ctrl = '0;
    if (accept) begin
      case (in_data.operation)
        ccpf_pkg::OP_RESERVE: cr_ctrl.reserve = 1'b1;
        ccpf_pkg::OP_PUSH:    q_ctrl.push     = 1'b1;
        ccpf_pkg::OP_POP:     q_ctrl.pop      = 1'b1;
        default: ;
      endcase
    end
    // freed length follows a pop that actually took an entry
    cr_ctrl.release_len = q_stat.pop_taken;
  end

  ccpf_credit u_credit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (cr_ctrl),
    .req_len     (in_data.length_scaled),
    .freed_len   (q_stat.freed_len),
    .stat        (cr_stat)
  );

  ccpf_queue #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (q_ctrl),
    .push_handle (in_data.packet_handle),
    .push_len    (in_data.length_scaled),
    .stat        (q_stat)
  );

  // Oversized reserve and push into a full store are the two error cases
  always_comb begin
    err = ccpf_pkg::ERR_NONE;
    if (cr_stat.over_cap) begin
      err = ccpf_pkg::ERR_OVER_CAPACITY;
    end else if (q_ctrl.push && q_stat.full) begin
      err = ccpf_pkg::ERR_STORE_FULL;
    end
  end

  always_comb begin
    res_nxt.granted          = cr_stat.granted;
    res_nxt.error_code       = err;
    res_nxt.head_valid       = q_stat.head_valid;
    res_nxt.head_handle      = q_stat.head_handle;
    res_nxt.head_length_bits = q_stat.head_bits;
    res_nxt.occupancy_scaled = cr_stat.occupancy;
    res_nxt.entry_count      = q_stat.entry_count;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: loads only on an accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule
